// ----- hw/rtl/i2cm_pkg.sv -----
// Shared constants and types for the I2C register access master.
// No dependencies; compiled first.

package i2cm_pkg;

   localparam int unsigned FuncWidth   = 2;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CountWidth  = 9;
   localparam int unsigned StatusWidth = 3;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_ADDR_NACK = 3'd1,
      STATUS_REG_NACK  = 3'd2,
      STATUS_DATA_NACK = 3'd3,
      STATUS_RADR_NACK = 3'd4
   } status_type;

   localparam logic [CountWidth-1:0] MaxTransfer      = 9'd256;
   localparam logic [ByteWidth-1:0]  AckTimeoutReset  = 8'd100;

endpackage

// ----- hw/rtl/i2cm_ifs.sv -----
// Channel interfaces of the I2C register access master: request, response, csr.
// Depends on nothing; widths follow the field definitions in i2cm_pkg.

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] device_address;
   logic [7:0] register_address;
   logic [8:0] byte_count;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, func, device_address, register_address, byte_count,
                   write_data, sda_in, input ready);
   modport sink   (input valid, func, device_address, register_address, byte_count,
                   write_data, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       data_taken;
   logic       read_valid;
   logic [7:0] read_data;
   logic       done_res;
   logic [2:0] status;

   modport source  (output valid, scl_out, sda_out, busy_res, data_taken, read_valid,
                    read_data, done_res, status, input ready);
   modport sink    (input valid, scl_out, sda_out, busy_res, data_taken, read_valid,
                    read_data, done_res, status, output ready);
   modport monitor (input valid, ready, scl_out, sda_out, busy_res, data_taken, read_valid,
                    read_data, done_res, status);
endinterface

interface i2cm_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/i2c_master_register_access_top.sv -----
// Bit-level I2C master for register reads and writes; one request word is one bus tick.
// Depends on i2cm_pkg and the channel interfaces in i2cm_ifs.sv.
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------------------
//   req_bus  | in  | func, device_address, register_address, byte_count, write_data, sda_in
//   rsp_bus  | out | scl_out, sda_out, busy_res, data_taken, read_valid, read_data,
//            |     | done_res, status
//   csr_bus  | in  | ack_timeout (always ready)
//
// One request word per cycle unless req_bus stalls; each gives one response word,
// valid in the cycle after acceptance. The state machine steps once per accepted word.
// The response register is the only buffer: req_bus stalls while it is full and not taken.
// Synchronous active-high reset returns to idle with ack_timeout = 100.

module i2c_master_register_access_top (
   input  logic clock,
   input  logic reset,
   i2cm_req_if.sink   req_bus,
   i2cm_rsp_if.source rsp_bus,
   i2cm_csr_if.sink   csr_bus
);
   import i2cm_pkg::*;

   typedef enum logic [3:0] {
      P_IDLE, P_START_LOW, P_TX_LOW, P_TX_HIGH, P_ACK_LOW, P_ACK_HIGH,
      P_RS_LOW, P_RS_HIGH, P_RS_START, P_RX_LOW, P_RX_HIGH, P_MACK_LOW,
      P_MACK_HIGH, P_STOP_LOW, P_STOP_HIGH, P_STOP_END
   } phase_type;

   typedef enum logic [1:0] {
      K_ADDR, K_REG, K_RADDR, K_DATA
   } kind_type;

   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic [3:0]           bit_count_ff, bit_count_in;
   logic [7:0]           shift_ff, shift_in;
   logic [CountWidth-1:0] bytes_left_ff, bytes_left_in;
   logic [7:0]           ack_wait_ff, ack_wait_in;
   logic [7:0]           saved_device_ff, saved_device_in;
   logic [7:0]           saved_register_ff, saved_register_in;
   logic                 is_read_ff, is_read_in;
   status_type           error_code_ff, error_code_in;
   logic [7:0]           ack_timeout_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 scl_ff, scl_in, sda_ff, sda_in_w, busy_ff, busy_in;
   logic                 taken_ff, taken_in, rvalid_ff, rvalid_in, done_ff, done_in;
   logic [7:0]           rdata_ff, rdata_in;
   status_type           status_ff, status_in;

   logic                 req_fire;
   logic [7:0]           limit;
   logic [7:0]           ack_wait_inc;
   logic [7:0]           shift_rx;
   logic [CountWidth-1:0] cnt_sat;
   logic [CountWidth-1:0] bytes_dec;
   status_type           nack_code;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign limit        = (ack_timeout_ff == 8'd0) ? 8'd1 : ack_timeout_ff;
   assign ack_wait_inc = ack_wait_ff + 8'd1;
   assign shift_rx     = {shift_ff[6:0], req_bus.sda_in};
   assign bytes_dec    = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;
   assign cnt_sat      = (req_bus.byte_count == '0) ? CountWidth'(1) :
                         (req_bus.byte_count > MaxTransfer) ? MaxTransfer : req_bus.byte_count;

   always_comb begin
      unique case (kind_ff)
         K_ADDR:  nack_code = STATUS_ADDR_NACK;
         K_REG:   nack_code = STATUS_REG_NACK;
         K_DATA:  nack_code = STATUS_DATA_NACK;
         default: nack_code = STATUS_RADR_NACK;
      endcase
   end

   always_comb begin
      phase_in          = phase_ff;
      kind_in           = kind_ff;
      bit_count_in      = bit_count_ff;
      shift_in          = shift_ff;
      bytes_left_in     = bytes_left_ff;
      ack_wait_in       = ack_wait_ff;
      saved_device_in   = saved_device_ff;
      saved_register_in = saved_register_ff;
      is_read_in        = is_read_ff;
      error_code_in     = error_code_ff;
      scl_in            = 1'b1;
      sda_in_w          = 1'b1;
      busy_in           = 1'b1;
      taken_in          = 1'b0;
      rvalid_in         = 1'b0;
      rdata_in          = 8'd0;
      done_in           = 1'b0;
      status_in         = STATUS_OK;

      unique case (phase_ff)
         P_IDLE: begin
            if (req_bus.func == FUNC_WRITE || req_bus.func == FUNC_READ) begin
               saved_device_in   = req_bus.device_address;
               saved_register_in = req_bus.register_address;
               is_read_in        = (req_bus.func == FUNC_READ);
               bytes_left_in     = cnt_sat;
               error_code_in     = STATUS_OK;
               ack_wait_in       = 8'd0;
               bit_count_in      = 4'd0;
               kind_in           = K_ADDR;
               shift_in          = req_bus.device_address;
               sda_in_w          = 1'b0;
               phase_in          = P_START_LOW;
            end else begin
               busy_in = 1'b0;
            end
         end
         P_START_LOW: begin
            scl_in       = 1'b0;
            sda_in_w     = 1'b0;
            bit_count_in = 4'd0;
            phase_in     = P_TX_LOW;
         end
         P_TX_LOW: begin
            scl_in   = 1'b0;
            sda_in_w = shift_ff[7];
            if (bit_count_ff == 4'd0 && kind_ff == K_DATA) begin
               shift_in = req_bus.write_data;
               sda_in_w = req_bus.write_data[7];
               taken_in = 1'b1;
            end
            phase_in = P_TX_HIGH;
         end
         P_TX_HIGH: begin
            sda_in_w = shift_ff[7];
            shift_in = {shift_ff[6:0], 1'b0};
            if (bit_count_ff >= 4'd7) begin
               bit_count_in = 4'd0;
               ack_wait_in  = 8'd0;
               phase_in     = P_ACK_LOW;
            end else begin
               bit_count_in = bit_count_ff + 4'd1;
               phase_in     = P_TX_LOW;
            end
         end
         P_ACK_LOW: begin
            scl_in   = 1'b0;
            phase_in = P_ACK_HIGH;
         end
         P_ACK_HIGH: begin
            if (!req_bus.sda_in) begin
               bit_count_in = 4'd0;
               unique case (kind_ff)
                  K_ADDR: begin
                     kind_in  = K_REG;
                     shift_in = saved_register_ff;
                     phase_in = P_TX_LOW;
                  end
                  K_REG: begin
                     if (is_read_ff) begin
                        phase_in = P_RS_LOW;
                     end else begin
                        kind_in  = K_DATA;
                        phase_in = P_TX_LOW;
                     end
                  end
                  K_DATA: begin
                     bytes_left_in = bytes_dec;
                     phase_in      = (bytes_dec == '0) ? P_STOP_LOW : P_TX_LOW;
                  end
                  default: begin
                     shift_in = 8'd0;
                     phase_in = P_RX_LOW;
                  end
               endcase
            end else begin
               ack_wait_in = ack_wait_inc;
               if (ack_wait_inc == 8'd0 || ack_wait_inc >= limit) begin
                  error_code_in = nack_code;
                  phase_in      = P_STOP_LOW;
               end
            end
         end
         P_RS_LOW: begin
            scl_in   = 1'b0;
            phase_in = P_RS_HIGH;
         end
         P_RS_HIGH: begin
            phase_in = P_RS_START;
         end
         P_RS_START: begin
            sda_in_w = 1'b0;
            kind_in  = K_RADDR;
            shift_in = saved_device_ff + 8'd1;
            phase_in = P_START_LOW;
         end
         P_RX_LOW: begin
            scl_in   = 1'b0;
            phase_in = P_RX_HIGH;
         end
         P_RX_HIGH: begin
            shift_in = shift_rx;
            if (bit_count_ff >= 4'd7) begin
               bit_count_in  = 4'd0;
               rvalid_in     = 1'b1;
               rdata_in      = shift_rx;
               bytes_left_in = bytes_dec;
               phase_in      = P_MACK_LOW;
            end else begin
               bit_count_in = bit_count_ff + 4'd1;
               phase_in     = P_RX_LOW;
            end
         end
         P_MACK_LOW: begin
            scl_in   = 1'b0;
            sda_in_w = (bytes_left_ff == '0);
            phase_in = P_MACK_HIGH;
         end
         P_MACK_HIGH: begin
            sda_in_w = (bytes_left_ff == '0);
            if (bytes_left_ff == '0) begin
               phase_in = P_STOP_LOW;
            end else begin
               shift_in = 8'd0;
               phase_in = P_RX_LOW;
            end
         end
         P_STOP_LOW: begin
            scl_in   = 1'b0;
            sda_in_w = 1'b0;
            phase_in = P_STOP_HIGH;
         end
         P_STOP_HIGH: begin
            sda_in_w = 1'b0;
            phase_in = P_STOP_END;
         end
         P_STOP_END: begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            status_in = error_code_ff;
            phase_in  = P_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            phase_in = P_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= P_IDLE;
         kind_ff           <= K_ADDR;
         bit_count_ff      <= 4'd0;
         shift_ff          <= 8'd0;
         bytes_left_ff     <= '0;
         ack_wait_ff       <= 8'd0;
         saved_device_ff   <= 8'd0;
         saved_register_ff <= 8'd0;
         is_read_ff        <= 1'b0;
         error_code_ff     <= STATUS_OK;
         ack_timeout_ff    <= AckTimeoutReset;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            ack_timeout_ff <= csr_bus.data;
         end
         if (req_fire) begin
            phase_ff          <= phase_in;
            kind_ff           <= kind_in;
            bit_count_ff      <= bit_count_in;
            shift_ff          <= shift_in;
            bytes_left_ff     <= bytes_left_in;
            ack_wait_ff       <= ack_wait_in;
            saved_device_ff   <= saved_device_in;
            saved_register_ff <= saved_register_in;
            is_read_ff        <= is_read_in;
            error_code_ff     <= error_code_in;
         end
      end
      if (req_fire) begin
         scl_ff    <= scl_in;
         sda_ff    <= sda_in_w;
         busy_ff   <= busy_in;
         taken_ff  <= taken_in;
         rvalid_ff <= rvalid_in;
         rdata_ff  <= rdata_in;
         done_ff   <= done_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.scl_out    = scl_ff;
   assign rsp_bus.sda_out    = sda_ff;
   assign rsp_bus.busy_res   = busy_ff;
   assign rsp_bus.data_taken = taken_ff;
   assign rsp_bus.read_valid = rvalid_ff;
   assign rsp_bus.read_data  = rdata_ff;
   assign rsp_bus.done_res   = done_ff;
   assign rsp_bus.status     = status_ff;

endmodule

// ----- hw/rtl/i2cm_checker.sv -----
// Port-level checks on the response channel of the I2C register access master.
// Depends on i2cm_pkg; bound to i2c_master_register_access_top.

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_out,
   input logic       rsp_sda_out,
   input logic       rsp_busy_res,
   input logic       rsp_data_taken,
   input logic       rsp_read_valid,
   input logic [7:0] rsp_read_data,
   input logic       rsp_done_res,
   input logic [2:0] rsp_status
);
   import i2cm_pkg::*;

   // a finished transaction leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done word shows busy");

   // status only reports with done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == STATUS_OK)
      else $error("status without done");

   // data load and byte receive happen inside a transaction, never together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data_taken || rsp_read_valid)
         |-> rsp_busy_res && !(rsp_data_taken && rsp_read_valid))
      else $error("data strobe outside transaction");

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_data) && $stable(rsp_scl_out)
         && $stable(rsp_sda_out))
      else $error("response changed while stalled");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_scl_out    (rsp_bus.scl_out),
   .rsp_sda_out    (rsp_bus.sda_out),
   .rsp_busy_res   (rsp_bus.busy_res),
   .rsp_data_taken (rsp_bus.data_taken),
   .rsp_read_valid (rsp_bus.read_valid),
   .rsp_read_data  (rsp_bus.read_data),
   .rsp_done_res   (rsp_bus.done_res),
   .rsp_status     (rsp_bus.status)
);

// ----- dv/tb_i2c_master_register_access_top.sv -----
// Testbench for i2c_master_register_access_top: self-checking, one request word per bus tick.
// Steers slave ACK/NACK on SDA, predicts every response word and compares field by field.
// Depends on i2cm_pkg, the channel interfaces in i2cm_ifs.sv and the top-level RTL.
`timescale 1ns / 100ps

module tb_i2c_master_register_access_top;
   import i2cm_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE       = 5'd0,
      PH_START_LOW  = 5'd1,
      PH_TX_LOW     = 5'd2,
      PH_TX_HIGH    = 5'd3,
      PH_ACK_LOW    = 5'd4,
      PH_ACK_HIGH   = 5'd5,
      PH_RS_LOW     = 5'd6,
      PH_RS_HIGH    = 5'd7,
      PH_RS_START   = 5'd8,
      PH_RX_LOW     = 5'd9,
      PH_RX_HIGH    = 5'd10,
      PH_MACK_LOW   = 5'd11,
      PH_MACK_HIGH  = 5'd12,
      PH_STOP_LOW   = 5'd13,
      PH_STOP_HIGH  = 5'd14,
      PH_STOP_END   = 5'd15
   } bus_phase_type;

   typedef enum logic [1:0] {
      KIND_ADDR  = 2'd0,
      KIND_REG   = 2'd1,
      KIND_RADDR = 2'd2,
      KIND_DATA  = 2'd3
   } byte_kind_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [8:0] byte_count;
      logic [7:0] write_data;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       data_taken;
      logic       read_valid;
      logic [7:0] read_data;
      logic       done_res;
      status_type status;
   } rsp_word_type;

   typedef struct packed {
      bus_phase_type phase;
      logic [3:0]    bit_count;
      logic [7:0]    shift_reg;
      logic [8:0]    bytes_left;
      logic [7:0]    ack_wait_count;
      logic [7:0]    saved_device;
      logic [7:0]    saved_register;
      logic          is_read;
      status_type    error_code;
      byte_kind_type kind;
      logic [7:0]    ack_timeout;
   } bus_state_type;

   logic clock;
   logic reset;

   i2cm_req_if req_bus ();
   i2cm_rsp_if rsp_bus ();
   i2cm_csr_if csr_bus ();

   i2c_master_register_access_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   req_word_type  pending_words[$];
   rsp_word_type  predicted_rsp[$];
   bus_state_type stim_model;
   bus_state_type bus_model;
   int unsigned   words_queued;
   int unsigned   words_sent;
   int unsigned   words_accepted;
   int unsigned   send_idle_pct;
   int unsigned   recv_stall_pct;
   int unsigned   failures;

   always #10 clock = ~clock;

   function automatic bus_state_type idle_state();
      bus_state_type s;
      s = '0;
      s.phase       = PH_IDLE;
      s.kind        = KIND_ADDR;
      s.error_code  = STATUS_OK;
      s.ack_timeout = AckTimeoutReset;
      return s;
   endfunction

   function automatic rsp_word_type master_tick(inout bus_state_type s,
                                                input req_word_type w);
      rsp_word_type r;
      logic [8:0]   count;
      logic [7:0]   limit;
      r = '0;
      r.scl_out  = 1'b1;
      r.sda_out  = 1'b1;
      r.busy_res = 1'b1;
      limit = (s.ack_timeout == 8'd0) ? 8'd1 : s.ack_timeout;
      case (s.phase)
         PH_IDLE: begin
            if (w.func == FUNC_WRITE || w.func == FUNC_READ) begin
               s.saved_device   = w.device_address;
               s.saved_register = w.register_address;
               s.is_read        = (w.func == FUNC_READ);
               count = w.byte_count;
               if (count == 9'd0) count = 9'd1;
               if (count > MaxTransfer) count = MaxTransfer;
               s.bytes_left     = count;
               s.error_code     = STATUS_OK;
               s.ack_wait_count = 8'd0;
               s.bit_count      = 4'd0;
               s.kind           = KIND_ADDR;
               s.shift_reg      = w.device_address;
               r.sda_out        = 1'b0;
               s.phase          = PH_START_LOW;
            end else begin
               r.busy_res = 1'b0;
            end
         end
         PH_START_LOW: begin
            r.scl_out   = 1'b0;
            r.sda_out   = 1'b0;
            s.bit_count = 4'd0;
            s.phase     = PH_TX_LOW;
         end
         PH_TX_LOW: begin
            if (s.bit_count == 4'd0 && s.kind == KIND_DATA) begin
               s.shift_reg  = w.write_data;
               r.data_taken = 1'b1;
            end
            r.scl_out = 1'b0;
            r.sda_out = s.shift_reg[7];
            s.phase   = PH_TX_HIGH;
         end
         PH_TX_HIGH: begin
            r.sda_out   = s.shift_reg[7];
            s.shift_reg = {s.shift_reg[6:0], 1'b0};
            s.bit_count = s.bit_count + 4'd1;
            if (s.bit_count >= 4'd8) begin
               s.bit_count      = 4'd0;
               s.ack_wait_count = 8'd0;
               s.phase          = PH_ACK_LOW;
            end else begin
               s.phase = PH_TX_LOW;
            end
         end
         PH_ACK_LOW: begin
            r.scl_out = 1'b0;
            s.phase   = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            if (!w.sda_in) begin
               s.bit_count = 4'd0;
               case (s.kind)
                  KIND_ADDR: begin
                     s.kind      = KIND_REG;
                     s.shift_reg = s.saved_register;
                     s.phase     = PH_TX_LOW;
                  end
                  KIND_REG: begin
                     if (s.is_read) begin
                        s.phase = PH_RS_LOW;
                     end else begin
                        s.kind  = KIND_DATA;
                        s.phase = PH_TX_LOW;
                     end
                  end
                  KIND_DATA: begin
                     if (s.bytes_left != 9'd0) s.bytes_left = s.bytes_left - 9'd1;
                     s.phase = (s.bytes_left == 9'd0) ? PH_STOP_LOW : PH_TX_LOW;
                  end
                  default: begin
                     s.shift_reg = 8'd0;
                     s.phase     = PH_RX_LOW;
                  end
               endcase
            end else begin
               s.ack_wait_count = s.ack_wait_count + 8'd1;
               if (s.ack_wait_count == 8'd0 || s.ack_wait_count >= limit) begin
                  case (s.kind)
                     KIND_ADDR: s.error_code = STATUS_ADDR_NACK;
                     KIND_REG:  s.error_code = STATUS_REG_NACK;
                     KIND_DATA: s.error_code = STATUS_DATA_NACK;
                     default:   s.error_code = STATUS_RADR_NACK;
                  endcase
                  s.phase = PH_STOP_LOW;
               end
            end
         end
         PH_RS_LOW: begin
            r.scl_out = 1'b0;
            s.phase   = PH_RS_HIGH;
         end
         PH_RS_HIGH: begin
            s.phase = PH_RS_START;
         end
         PH_RS_START: begin
            r.sda_out   = 1'b0;
            s.kind      = KIND_RADDR;
            s.shift_reg = s.saved_device + 8'd1;
            s.phase     = PH_START_LOW;
         end
         PH_RX_LOW: begin
            r.scl_out = 1'b0;
            s.phase   = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            s.shift_reg = {s.shift_reg[6:0], w.sda_in};
            s.bit_count = s.bit_count + 4'd1;
            if (s.bit_count >= 4'd8) begin
               s.bit_count  = 4'd0;
               r.read_valid = 1'b1;
               r.read_data  = s.shift_reg;
               if (s.bytes_left != 9'd0) s.bytes_left = s.bytes_left - 9'd1;
               s.phase = PH_MACK_LOW;
            end else begin
               s.phase = PH_RX_LOW;
            end
         end
         PH_MACK_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = (s.bytes_left == 9'd0);
            s.phase   = PH_MACK_HIGH;
         end
         PH_MACK_HIGH: begin
            r.sda_out = (s.bytes_left == 9'd0);
            if (s.bytes_left == 9'd0) begin
               s.phase = PH_STOP_LOW;
            end else begin
               s.shift_reg = 8'd0;
               s.phase     = PH_RX_LOW;
            end
         end
         PH_STOP_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = 1'b0;
            s.phase   = PH_STOP_HIGH;
         end
         PH_STOP_HIGH: begin
            r.sda_out = 1'b0;
            s.phase   = PH_STOP_END;
         end
         PH_STOP_END: begin
            r.busy_res = 1'b0;
            r.done_res = 1'b1;
            r.status   = s.error_code;
            s.phase    = PH_IDLE;
         end
         default: begin
            r.busy_res = 1'b0;
            s.phase    = PH_IDLE;
         end
      endcase
      return r;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.func             = func_type'($urandom_range(0, 3));
      w.device_address   = 8'($urandom);
      w.register_address = 8'($urandom);
      w.byte_count       = 9'($urandom);
      w.write_data       = 8'($urandom);
      w.sda_in           = 1'($urandom);
      return w;
   endfunction

   task automatic queue_word(input req_word_type w);
      pending_words.push_back(w);
      void'(master_tick(stim_model, w));
      words_queued++;
   endtask

   task automatic idle_gap(input int unsigned n);
      req_word_type w;
      repeat (n) begin
         w = random_word();
         w.func = $urandom_range(0, 1) ? FUNC_TICK : FUNC_NONE;
         queue_word(w);
      end
   endtask

   // Slave side: ACK with a few random wait ticks, or hold SDA high on the
   // chosen byte until the master times out.
   task automatic run_transfer(input func_type op, input logic [7:0] dev,
                               input logic [7:0] regaddr, input logic [8:0] count,
                               input logic refuse_ack, input byte_kind_type refuse_kind);
      req_word_type w;
      logic         refusing;
      logic [7:0]   limit;
      refusing = 1'b0;
      w = random_word();
      w.func             = op;
      w.device_address   = dev;
      w.register_address = regaddr;
      w.byte_count       = count;
      queue_word(w);
      while (stim_model.phase != PH_IDLE) begin
         w = random_word();
         if (stim_model.phase == PH_ACK_HIGH) begin
            limit = (stim_model.ack_timeout == 8'd0) ? 8'd1 : stim_model.ack_timeout;
            if (refuse_ack && stim_model.kind == refuse_kind &&
                (refuse_kind != KIND_DATA || stim_model.bytes_left == 9'd1 ||
                 $urandom_range(0, 2) == 0))
               refusing = 1'b1;
            w.sda_in = refusing || ($urandom_range(0, 3) == 0 &&
                       ({1'b0, stim_model.ack_wait_count} + 9'd1 < {1'b0, limit}));
         end
         queue_word(w);
      end
   endtask

   task automatic random_transfer();
      func_type   op;
      logic [8:0] count;
      op    = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      count = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(3, 5))
                                          : 9'($urandom_range(0, 2));
      run_transfer(op, 8'($urandom), 8'($urandom), count, $urandom_range(0, 9) < 4,
                   byte_kind_type'($urandom_range(0, 3)));
      idle_gap($urandom_range(0, 3));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (words_accepted != words_queued || predicted_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_ack_timeout(input logic [7:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      stim_model.ack_timeout = value;
      bus_model.ack_timeout  = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // driver: one word in flight, next one loaded once the last was taken
   always @(negedge clock) begin : req_driver
      req_word_type next_word;
      if (!reset && (!req_bus.valid || words_accepted == words_sent)) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_word = pending_words.pop_front();
            req_bus.valid            <= 1'b1;
            req_bus.func             <= next_word.func;
            req_bus.device_address   <= next_word.device_address;
            req_bus.register_address <= next_word.register_address;
            req_bus.byte_count       <= next_word.byte_count;
            req_bus.write_data       <= next_word.write_data;
            req_bus.sda_in           <= next_word.sda_in;
            words_sent++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      req_word_type seen;
      rsp_word_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.func             = func_type'(req_bus.func);
            seen.device_address   = req_bus.device_address;
            seen.register_address = req_bus.register_address;
            seen.byte_count       = req_bus.byte_count;
            seen.write_data       = req_bus.write_data;
            seen.sda_in           = req_bus.sda_in;
            predicted_rsp.push_back(master_tick(bus_model, seen));
            words_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("response word with none outstanding");
               failures++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("scl_out", 8'(want.scl_out), 8'(rsp_bus.scl_out));
               check_field("sda_out", 8'(want.sda_out), 8'(rsp_bus.sda_out));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_bus.busy_res));
               check_field("data_taken", 8'(want.data_taken), 8'(rsp_bus.data_taken));
               check_field("read_valid", 8'(want.read_valid), 8'(rsp_bus.read_valid));
               check_field("read_data", want.read_data, rsp_bus.read_data);
               check_field("done_res", 8'(want.done_res), 8'(rsp_bus.done_res));
               check_field("status", 8'(want.status), 8'(rsp_bus.status));
            end
         end
      end
   end

   initial begin
      req_word_type w;
      int unsigned  send_pct[4];
      int unsigned  recv_pct[4];
      logic [7:0]   timeouts[4];
      int unsigned  target;
      int unsigned  random_base;
      clock          = 1'b0;
      reset          = 1'b1;
      failures       = 0;
      words_queued   = 0;
      words_sent     = 0;
      words_accepted = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stim_model     = idle_state();
      bus_model      = idle_state();
      req_bus.valid  = 1'b0;
      req_bus.func   = FUNC_TICK;
      req_bus.device_address   = '0;
      req_bus.register_address = '0;
      req_bus.byte_count       = '0;
      req_bus.write_data       = '0;
      req_bus.sda_in           = 1'b1;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle ticks, zero count, address wrap
      w = '1;
      w.func = FUNC_NONE;
      queue_word(w);
      w = '0;
      w.func = FUNC_TICK;
      queue_word(w);
      run_transfer(FUNC_WRITE, 8'h00, 8'hFF, 9'd0, 1'b0, KIND_ADDR);
      run_transfer(FUNC_READ, 8'hFF, 8'h5A, 9'd2, 1'b0, KIND_ADDR);
      idle_gap(2);

      // zero timeout acts as one tick; oversized write count
      set_ack_timeout(8'd0);
      run_transfer(FUNC_WRITE, 8'hA5, 8'h3C, 9'h1FF, 1'b1, KIND_DATA);
      run_transfer(FUNC_READ, 8'h51, 8'h06, 9'd2, 1'b1, KIND_RADDR);

      send_pct = '{0, 67, 0, 10};
      recv_pct = '{0, 0, 67, 10};
      timeouts = '{8'd3, 8'd1, 8'($urandom_range(2, 10)), 8'($urandom_range(1, 16))};
      random_base = words_queued;
      for (int i = 0; i < 4; i++) begin
         set_ack_timeout(timeouts[i]);
         send_idle_pct  = send_pct[i];
         recv_stall_pct = recv_pct[i];
         target = random_base + 60 * (i + 1);
         while (words_queued < target) random_transfer();
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_ifs.sv
hw/rtl/i2c_master_register_access_top.sv
hw/rtl/i2cm_checker.sv
dv/tb_i2c_master_register_access_top.sv
